[hdl/pip_pkg.sv]
// shared types and constants for the point-in-polygon test
// no dependencies; imported by pip_edge_eval and point_in_polygon_test
package pip_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CNT_W   = 7;
  localparam int IDX_W   = 6;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vertex_t;

  typedef struct packed {
    logic    vld;
    logic    tail;
    vertex_t v1;
    vertex_t v2;
  } edge_in_t;

  typedef struct packed {
    logic vld;
    logic hit;
    logic tail;
  } edge_res_t;

endpackage

[hdl/point_in_polygon_test.sv]
// top level: vertex memory, edge walk sequencer, crossing counter, result register
// depends on pip_pkg and pip_edge_eval
//
//  channel | ports                                   | transfer carries
//  in      | in_valid / in_ready                     | vertex write or point query
//  out     | out_valid / out_ready                   | inside flag and crossing count
//  cfg     | cfg_valid / cfg_ready                   | vertex count register
//
// a vertex write leaves the input ready; a query over n >= 3 vertices (count clamped)
// holds the input through n reads on the single memory read port, closing edge,
// three evaluator stages, finish, output load; with fewer than three vertices it
// goes straight to finish and holds the input until the output is loaded; reset
// clears control state and the vertex count only
// a waiting result lets new writes in; a later query holds in finish until it is taken
module point_in_polygon_test #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [pip_pkg::IDX_W-1:0]     in_vertex_index,
  input  logic signed [pip_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [pip_pkg::COORD_W-1:0] in_coord_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_inside_res,
  output logic [pip_pkg::CNT_W-1:0]     out_crossings,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pip_pkg::CNT_W-1:0]     cfg_vertex_count
);
  import pip_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] vcount_r;
  logic [NW-1:0]    n_r, n_clamp;
  logic [NW-1:0]    rd_idx_r;
  vertex_t          pt_r;
  logic [CNT_W-1:0] cnt_r;

  vertex_t          vert_mem_r [MAX_VERTICES];
  vertex_t          rd_data_r;
  logic             rd_vld_r, rd_first_r, rd_last_r, close_r;
  vertex_t          first_v_r, prev_v_r;

  logic             out_valid_r, out_inside_r;
  logic [CNT_W-1:0] out_crossings_r;

  logic             in_xfer, wr_en, query, rd_en, rd_last, load_out;
  edge_in_t         edge_in;
  edge_res_t        res;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign wr_en     = in_xfer && (in_req_type == REQ_WRITE) &&
                     (int'(in_vertex_index) < MAX_VERTICES);
  assign query     = in_xfer && (in_req_type == REQ_QUERY);
  assign rd_en     = (state_r == ST_WALK);
  assign rd_last   = (rd_idx_r == n_r - NW'(1));
  assign load_out  = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    if (int'(vcount_r) > MAX_VERTICES) begin
      n_clamp = NW'(MAX_VERTICES);
    end else begin
      n_clamp = NW'(vcount_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      vcount_r <= cfg_vertex_count;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (query) begin
          state_nxt = (n_clamp >= NW'(3)) ? ST_WALK : ST_FIN;
        end
      end
      ST_WALK: begin
        if (rd_last) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (res.vld && res.tail) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (query) begin
        rd_idx_r <= '0;
        cnt_r    <= '0;
      end else begin
        if (rd_en) begin
          rd_idx_r <= rd_idx_r + NW'(1);
        end
        if (res.vld && res.hit) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query) begin
      n_r  <= n_clamp;
      pt_r <= '{x: in_coord_x, y: in_coord_y};
    end
  end

  // vertex memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      vert_mem_r[AW'(in_vertex_index)] <= '{x: in_coord_x, y: in_coord_y};
    end
    if (rd_en) begin
      rd_data_r <= vert_mem_r[rd_idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r <= (rd_idx_r == '0);
    rd_last_r  <= rd_last;
    if (rd_vld_r) begin
      prev_v_r <= rd_data_r;
      if (rd_first_r) begin
        first_v_r <= rd_data_r;
      end
    end
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      close_r  <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      close_r  <= rd_vld_r && rd_last_r;
    end
  end

  // each read after the first forms an edge with the previous vertex; the closing edge follows
  always_comb begin
    edge_in.vld  = (rd_vld_r && !rd_first_r) || close_r;
    edge_in.tail = close_r;
    edge_in.v1   = prev_v_r;
    edge_in.v2   = close_r ? first_v_r : rd_data_r;
  end

  pip_edge_eval u_edge_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .pt      (pt_r),
    .edge_in (edge_in),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_crossings_r <= cnt_r;
      out_inside_r    <= cnt_r[0];
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_crossings  = out_crossings_r;

`ifndef SYNTHESIS
  a_res_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |-> (state_r == ST_WALK || state_r == ST_WAIT))
    else $error("edge result outside a query");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (rd_idx_r < n_r))
    else $error("vertex read beyond count");

  a_close_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (edge_in.vld && edge_in.tail) |-> (state_r == ST_WAIT))
    else $error("closing edge issued while still walking");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("result loaded outside finish state");
`endif

endmodule

[hdl/pip_edge_eval.sv]
// three-stage edge crossing evaluator: orient and span check, products, compare
// depends on pip_pkg
module pip_edge_eval (
  input  logic               clk,
  input  logic               rst_n,
  input  pip_pkg::vertex_t   pt,
  input  pip_pkg::edge_in_t  edge_in,
  output pip_pkg::edge_res_t res
);
  import pip_pkg::*;

  logic                     b_vld_r, b_use_r, b_tail_r;
  logic signed [DIFF_W-1:0] b_dyl_r, b_dx_r, b_dxp_r, b_dy_r;
  logic                     c_vld_r, c_use_r, c_tail_r;
  logic signed [PROD_W-1:0] c_pl_r, c_pr_r;
  edge_res_t                res_r;

  logic signed [COORD_W-1:0] xa, ya, xb, yb, px, py;
  logic                      horiz, in_span;
  logic signed [PROD_W-1:0]  pl_nxt, pr_nxt;

  // orient the edge upward and test the half-open y span
  always_comb begin
    px = pt.x;
    py = pt.y;
    horiz = (edge_in.v1.y == edge_in.v2.y);
    if (edge_in.v1.y < edge_in.v2.y) begin
      xa = edge_in.v1.x;
      ya = edge_in.v1.y;
      xb = edge_in.v2.x;
      yb = edge_in.v2.y;
    end else begin
      xa = edge_in.v2.x;
      ya = edge_in.v2.y;
      xb = edge_in.v1.x;
      yb = edge_in.v1.y;
    end
    in_span = (py >= ya) && (py < yb);
  end

  always_ff @(posedge clk) begin
    b_dyl_r <= DIFF_W'(py) - DIFF_W'(ya);
    b_dx_r  <= DIFF_W'(xb) - DIFF_W'(xa);
    b_dxp_r <= DIFF_W'(px) - DIFF_W'(xa);
    b_dy_r  <= DIFF_W'(yb) - DIFF_W'(ya);
    b_use_r <= !horiz && in_span;
    b_tail_r <= edge_in.tail;
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= edge_in.vld;
    end
  end

  assign pl_nxt = b_dyl_r * b_dx_r;
  assign pr_nxt = b_dxp_r * b_dy_r;

  always_ff @(posedge clk) begin
    c_pl_r   <= pl_nxt;
    c_pr_r   <= pr_nxt;
    c_use_r  <= b_use_r;
    c_tail_r <= b_tail_r;
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
  end

  // crossing lies strictly right of the point
  always_ff @(posedge clk) begin
    res_r.hit  <= c_use_r && (c_pl_r > c_pr_r);
    res_r.tail <= c_tail_r;
    if (!rst_n) begin
      res_r.vld <= 1'b0;
    end else begin
      res_r.vld <= c_vld_r;
    end
  end

  assign res = res_r;

endmodule

[tb/point_in_polygon_test_test.sv]
// testbench for point_in_polygon_test: vertex writes and point queries against an
// in-bench ray-casting predictor, with a directed table then random polygon phases
// depends on pip_pkg and point_in_polygon_test
module point_in_polygon_test_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pip_pkg::*;

  localparam int VERTEX_SLOTS  = 64;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 300;
  localparam int ONE_DEG       = 1 << 23;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;

  typedef enum logic [1:0] {ROW_WRITE, ROW_QUERY, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [CNT_W-1:0]          cnt;
    bit                        known;
    logic                      in_poly;
    logic [CNT_W-1:0]          crossings;
  } stim_row_t;

  typedef struct {
    logic             in_poly;
    logic [CNT_W-1:0] crossings;
  } pip_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_req_type;
  logic [IDX_W-1:0]          in_vertex_index;
  logic signed [COORD_W-1:0] in_coord_x;
  logic signed [COORD_W-1:0] in_coord_y;
  logic                      out_valid;
  logic                      out_ready;
  logic                      out_inside_res;
  logic [CNT_W-1:0]          out_crossings;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CNT_W-1:0]          cfg_vertex_count;

  logic signed [COORD_W-1:0] vert_x [VERTEX_SLOTS];
  logic signed [COORD_W-1:0] vert_y [VERTEX_SLOTS];
  bit                        vert_written [VERTEX_SLOTS];
  logic [CNT_W-1:0]          poly_count;
  pip_result_t               pending_results [$];
  pip_result_t               head_result;
  stim_row_t                 dir_rows [$];
  int                        mismatch_count;
  int                        send_idle_pct;
  int                        recv_stall_pct;
  bit                        hold_req;
  bit                        hold_ack;
  int                        hold_left;
  int                        phase_counts [16] = '{4, 3, 64, 0, 5, 127, 8, 2,
                                                  16, 65, 6, 1, 33, 7, 4, 12};

  point_in_polygon_test #(
    .MAX_VERTICES(VERTEX_SLOTS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_vertex_index (in_vertex_index),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_inside_res  (out_inside_res),
    .out_crossings   (out_crossings),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_vertex_count(cfg_vertex_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic pip_result_t count_crossings(logic signed [COORD_W-1:0] px,
                                                  logic signed [COORD_W-1:0] py);
    pip_result_t               res;
    int                        n;
    int                        j;
    int unsigned               cnt;
    logic signed [COORD_W-1:0] y1, y2, xa, ya, xb, yb;
    logic signed [DIFF_W-1:0]  dpy, dex, dpx, dey;
    logic signed [PROD_W-1:0]  lhs, rhs;
    n = (poly_count > VERTEX_SLOTS) ? VERTEX_SLOTS : int'(poly_count);
    cnt = 0;
    if (n >= 3) begin
      for (int i = 0; i < n; i++) begin
        j = (i + 1 == n) ? 0 : i + 1;
        y1 = vert_y[i];
        y2 = vert_y[j];
        if (y1 != y2) begin
          if (y1 < y2) begin
            xa = vert_x[i]; ya = y1; xb = vert_x[j]; yb = y2;
          end else begin
            xa = vert_x[j]; ya = y2; xb = vert_x[i]; yb = y1;
          end
          if (py >= ya && py < yb) begin
            dpy = DIFF_W'(py) - DIFF_W'(ya);
            dex = DIFF_W'(xb) - DIFF_W'(xa);
            dpx = DIFF_W'(px) - DIFF_W'(xa);
            dey = DIFF_W'(yb) - DIFF_W'(ya);
            lhs = PROD_W'(dpy) * PROD_W'(dex);
            rhs = PROD_W'(dpx) * PROD_W'(dey);
            if (lhs > rhs) cnt++;
          end
        end
      end
    end
    res.in_poly   = cnt[0];
    res.crossings = cnt[CNT_W-1:0];
    return res;
  endfunction

  function automatic stim_row_t mk(row_kind_t kind, int idx, int x, int y, int cnt = 0,
                                   bit known = 0, bit in_poly = 0, int crossings = 0);
    stim_row_t r;
    r.kind      = kind;
    r.idx       = idx[IDX_W-1:0];
    r.x         = x;
    r.y         = y;
    r.cnt       = cnt[CNT_W-1:0];
    r.known     = known;
    r.in_poly   = in_poly;
    r.crossings = crossings[CNT_W-1:0];
    return r;
  endfunction

  function automatic void add_row(stim_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord(int center, int span);
    case ($urandom_range(31))
      0: return COORD_MIN;
      1: return COORD_MAX;
      default: begin
        if (span == 0) return $urandom;
        return center + int'($urandom_range(2 * span)) - span;
      end
    endcase
  endfunction

  task automatic send_item(stim_row_t r);
    pip_result_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= (r.kind == ROW_QUERY) ? REQ_QUERY : REQ_WRITE;
    in_vertex_index <= r.idx;
    in_coord_x      <= r.x;
    in_coord_y      <= r.y;
    do @(posedge clk); while (!in_ready);
    if (r.kind == ROW_WRITE) begin
      vert_x[r.idx]       = r.x;
      vert_y[r.idx]       = r.y;
      vert_written[r.idx] = 1'b1;
    end else if (r.known) begin
      predicted.in_poly   = r.in_poly;
      predicted.crossings = r.crossings;
      pending_results.insert(pending_results.size(), predicted);
    end else begin
      pending_results.insert(pending_results.size(), count_crossings(r.x, r.y));
    end
  endtask

  // block goes quiet: no input, nothing outstanding, and any write fully absorbed
  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [CNT_W-1:0] cnt);
    wait_quiet();
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_vertex_count <= cnt;
    do @(posedge clk); while (!cfg_ready);
    poly_count = cnt;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_ack  = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: inside_res %0b crossings %0d",
               out_inside_res, out_crossings);
        mismatch_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (out_inside_res !== head_result.in_poly) begin
          $error("inside_res: expected %0b, actual %0b", head_result.in_poly,
                 out_inside_res);
          mismatch_count++;
        end
        if (out_crossings !== head_result.crossings) begin
          $error("crossings: expected %0d, actual %0d", head_result.crossings,
                 out_crossings);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_req_type      = REQ_WRITE;
    in_vertex_index  = '0;
    in_coord_x       = '0;
    in_coord_y       = '0;
    cfg_valid        = 1'b0;
    cfg_vertex_count = '0;
    hold_req         = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    mismatch_count   = 0;
    poly_count       = '0;
    foreach (vert_written[i]) vert_written[i] = 1'b0;

    // directed table: square around the origin, then a triangle at the coordinate extremes
    add_row(mk(ROW_QUERY, 5, COORD_MAX, COORD_MIN, 0, 1, 0, 0));
    add_row(mk(ROW_WRITE, 0, -ONE_DEG, -ONE_DEG));
    add_row(mk(ROW_WRITE, 1, ONE_DEG, -ONE_DEG));
    add_row(mk(ROW_WRITE, 2, ONE_DEG, ONE_DEG));
    add_row(mk(ROW_WRITE, 3, -ONE_DEG, ONE_DEG));
    add_row(mk(ROW_CFG, 0, 0, 0, 2));
    add_row(mk(ROW_QUERY, 0, 0, 0, 0, 1, 0, 0));
    add_row(mk(ROW_CFG, 0, 0, 0, 4));
    add_row(mk(ROW_QUERY, 63, 0, 0, 0, 1, 1, 1));
    add_row(mk(ROW_QUERY, 0, 2 * ONE_DEG, 0, 0, 1, 0, 0));
    add_row(mk(ROW_QUERY, 0, 0, -ONE_DEG));
    add_row(mk(ROW_QUERY, 0, 0, ONE_DEG));
    add_row(mk(ROW_QUERY, 0, ONE_DEG, 0));
    add_row(mk(ROW_QUERY, 0, -ONE_DEG, 0));
    add_row(mk(ROW_WRITE, 63, COORD_MAX, COORD_MIN));
    add_row(mk(ROW_WRITE, 0, COORD_MIN, COORD_MIN));
    add_row(mk(ROW_WRITE, 1, COORD_MAX, 0));
    add_row(mk(ROW_WRITE, 2, COORD_MIN, COORD_MAX));
    add_row(mk(ROW_CFG, 0, 0, 0, 3));
    add_row(mk(ROW_QUERY, 0, COORD_MIN, COORD_MIN));
    add_row(mk(ROW_QUERY, 0, COORD_MAX, COORD_MAX));
    add_row(mk(ROW_QUERY, 0, COORD_MIN, -1));
    add_row(mk(ROW_QUERY, 0, 0, 0));
    add_row(mk(ROW_QUERY, 0, COORD_MAX, 1));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_count(dir_rows[i].cnt);
      else send_item(dir_rows[i]);
    end

    for (int p = 0; p < 16; p++) begin
      int        n;
      int        k;
      int        center;
      int        span;
      stim_row_t r;
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      center = int'($urandom) >>> 2;
      case (p % 3)
        0: span = 1024;
        1: span = ONE_DEG;
        default: span = 0;
      endcase
      write_count(phase_counts[p][CNT_W-1:0]);
      n = (phase_counts[p] > VERTEX_SLOTS) ? VERTEX_SLOTS : phase_counts[p];

      // polygon vertices first so that every query reads written slots
      for (int i = 0; i < n; i++) begin
        if (n <= 16 || !vert_written[i]) begin
          send_item(mk(ROW_WRITE, i, rand_coord(center, span), rand_coord(center, span)));
        end
      end

      if (p == 4 || p == 14) hold_req = ~hold_req;

      for (int m = 0; m < 25; m++) begin
        if ($urandom_range(99) < 75) begin
          r = mk(ROW_QUERY, $urandom_range(63), rand_coord(center, span),
                 rand_coord(center, span));
          if (n > 0 && $urandom_range(99) < 30) begin
            k = $urandom_range(n - 1);
            r.y = vert_y[k];
            if ($urandom_range(1) == 0) r.x = vert_x[k];
          end
        end else begin
          r = mk(ROW_WRITE, $urandom_range(63), rand_coord(center, span),
                 rand_coord(center, span));
        end
        send_item(r);
      end
    end

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
